/* rtl/shadow_call_stack_tracker_core_defines.svh */
// ----------------------------------------------------------------------------
// shadow_call_stack_tracker_core_defines
// Assertion helpers for the shadow call stack tracker core.
// ----------------------------------------------------------------------------
`ifndef SHADOW_CALL_STACK_TRACKER_CORE_DEFINES_SVH
`define SHADOW_CALL_STACK_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent check, clocked on the rising edge and disabled during reset.
`define SCST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("scst assertion failed");

// Same check, but also evaluated while reset is asserted.
`define SCST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("scst assertion failed");

`else

`define SCST_ASSERT(lbl, clk, rstn, prop)
`define SCST_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/scst_pkg.sv */
// ----------------------------------------------------------------------------
// scst_pkg
// Shared types and constants of the shadow call stack tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package scst_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned DEPTH_W     = 6;

  typedef enum logic [2:0] {
    KIND_ENTER  = 3'd0,
    KIND_UNWIND = 3'd1,
    KIND_RETURN = 3'd2,
    KIND_UNDER  = 3'd3,
    KIND_OVER   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_FINAL = 3'b100
  } state_e;

  // One saved frame: stack pointer at the call and the called routine.
  typedef struct packed {
    logic [ADDR_W-1:0] sp;
    logic [ADDR_W-1:0] routine;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/scst_frame_ram.sv */
// ----------------------------------------------------------------------------
// scst_frame_ram
// Single-write, single-read frame store with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scst_frame_ram #(
  parameter int unsigned Depth = scst_pkg::STACK_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire scst_pkg::frame_t    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output      scst_pkg::frame_t    rdata_o
);

  scst_pkg::frame_t mem_q [Depth];
  scst_pkg::frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/shadow_call_stack_tracker_core.sv */
// ----------------------------------------------------------------------------
// shadow_call_stack_tracker_core
// Shadow call stack kept in a frame memory, driven by call and return words.
// ----------------------------------------------------------------------------
// Usage:
//   An input word (req_type_i, target_i, stack_ptr_i, call_site_i) is taken
//   at a rising edge where start_i is high and busy_o is low. busy_o stays
//   high until every result of that word has been produced.
//   Each result word appears on the result ports for exactly one cycle with
//   evt_valid_o high; last_o marks the final result of an input word. The
//   receiver cannot stall, so results are simply presented and dropped.
//   When the stack is not empty, the accepting edge reads the top frame from
//   the memory, and ST_CHECK then compares, emits and writes back. Each
//   unwound frame adds another pass through ST_CHECK, since every pop needs
//   a fresh read of the next frame through the single read port. A word on
//   an empty stack goes through ST_FINAL instead. Results are registered, so
//   the last result appears in the cycle in which busy_o has already dropped.
//   Reset clears the state, the frame count and the result valid and last
//   flags; the frame memory holds no defined contents and needs no
//   clearing pass, since only pushed frames are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shadow_call_stack_tracker_core_defines.svh"

module shadow_call_stack_tracker_core #(
  parameter int unsigned StackDepth = scst_pkg::STACK_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic                          req_type_i,
  input  wire logic [scst_pkg::ADDR_W-1:0]   target_i,
  input  wire logic [scst_pkg::ADDR_W-1:0]   stack_ptr_i,
  input  wire logic [scst_pkg::ADDR_W-1:0]   call_site_i,
  output      logic                          evt_valid_o,
  output      logic [2:0]                    event_kind_o,
  output      logic [scst_pkg::ADDR_W-1:0]   routine_o,
  output      logic [scst_pkg::ADDR_W-1:0]   site_o,
  output      logic [scst_pkg::DEPTH_W-1:0]  depth_o,
  output      logic                          last_o
);

  localparam int unsigned AW = $clog2(StackDepth);
  localparam int unsigned TW = $clog2(StackDepth + 1);
  localparam int unsigned DW = scst_pkg::DEPTH_W;
  localparam int unsigned XW = scst_pkg::ADDR_W;

  // Control state.
  scst_pkg::state_e state_q, state_d;
  logic [TW-1:0]    top_q, top_d;

  // Latched input word.
  logic          is_ret_q;
  logic [XW-1:0] tgt_q, sp_q, site_q;

  // Registered result word.
  logic            out_valid_q, out_valid_d;
  scst_pkg::kind_e out_kind_q, out_kind_d;
  logic [XW-1:0]   out_routine_q, out_routine_d;
  logic [XW-1:0]   out_site_q, out_site_d;
  logic [TW-1:0]   out_depth_q, out_depth_d;
  logic            out_last_q, out_last_d;

  // Frame memory ports.
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr;
  scst_pkg::frame_t rd_frame, wr_frame;

  logic [TW-1:0] top_m1, top_m2;
  logic          unwind_hit, stack_full;

  assign top_m1     = top_q - TW'(1);
  assign top_m2     = top_q - TW'(2);
  // A frame whose saved pointer is at or below the current one is stale.
  assign unwind_hit = (sp_q >= rd_frame.sp);
  assign stack_full = (top_q == TW'(StackDepth));

  assign wr_frame.sp      = sp_q;
  assign wr_frame.routine = tgt_q;

  scst_frame_ram #(
    .Depth (StackDepth),
    .AddrW (AW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (top_q[AW-1:0]),
    .wdata_i (wr_frame),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_frame)
  );

  always_comb begin
    state_d       = state_q;
    top_d         = top_q;
    rd_en         = 1'b0;
    rd_addr       = top_m1[AW-1:0];
    wr_en         = 1'b0;
    out_valid_d   = 1'b0;
    out_kind_d    = scst_pkg::KIND_ENTER;
    out_routine_d = '0;
    out_site_d    = '0;
    out_depth_d   = top_q;
    out_last_d    = 1'b0;

    case (state_q)
      scst_pkg::ST_IDLE: begin
        if (start_i) begin
          if (top_q != '0) begin
            // Fetch the top frame for the unwind compare.
            rd_en   = 1'b1;
            state_d = scst_pkg::ST_CHECK;
          end else begin
            state_d = scst_pkg::ST_FINAL;
          end
        end
      end

      scst_pkg::ST_CHECK: begin
        out_valid_d = 1'b1;
        if (unwind_hit) begin
          // Pop a stale frame and look at the one below it, if any.
          out_kind_d    = scst_pkg::KIND_UNWIND;
          out_routine_d = rd_frame.routine;
          out_depth_d   = top_m1;
          top_d         = top_m1;
          if (top_m1 != '0) begin
            rd_en   = 1'b1;
            rd_addr = top_m2[AW-1:0];
          end else begin
            state_d = scst_pkg::ST_FINAL;
          end
        end else begin
          out_last_d = 1'b1;
          state_d    = scst_pkg::ST_IDLE;
          if (is_ret_q) begin
            // The frame just read is the one the return pops.
            out_kind_d    = scst_pkg::KIND_RETURN;
            out_routine_d = rd_frame.routine;
            out_depth_d   = top_m1;
            top_d         = top_m1;
          end else if (stack_full) begin
            out_kind_d    = scst_pkg::KIND_OVER;
            out_routine_d = tgt_q;
          end else begin
            wr_en         = 1'b1;
            out_kind_d    = scst_pkg::KIND_ENTER;
            out_routine_d = tgt_q;
            out_site_d    = site_q;
            out_depth_d   = top_q + TW'(1);
            top_d         = top_q + TW'(1);
          end
        end
      end

      scst_pkg::ST_FINAL: begin
        // The stack is empty here.
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        state_d     = scst_pkg::ST_IDLE;
        if (is_ret_q) begin
          out_kind_d  = scst_pkg::KIND_UNDER;
          out_depth_d = '0;
        end else if (stack_full) begin
          out_kind_d    = scst_pkg::KIND_OVER;
          out_routine_d = tgt_q;
        end else begin
          wr_en         = 1'b1;
          out_kind_d    = scst_pkg::KIND_ENTER;
          out_routine_d = tgt_q;
          out_site_d    = site_q;
          out_depth_d   = top_q + TW'(1);
          top_d         = top_q + TW'(1);
        end
      end

      default: begin
        state_d = scst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scst_pkg::ST_IDLE;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == scst_pkg::ST_IDLE)) begin
      is_ret_q <= req_type_i;
      tgt_q    <= target_i;
      sp_q     <= stack_ptr_i;
      site_q   <= call_site_i;
    end
    out_kind_q    <= out_kind_d;
    out_routine_q <= out_routine_d;
    out_site_q    <= out_site_d;
    out_depth_q   <= out_depth_d;
  end

  assign busy_o       = (state_q != scst_pkg::ST_IDLE);
  assign evt_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign routine_o    = out_routine_q;
  assign site_o       = out_site_q;
  assign depth_o      = DW'(out_depth_q);
  assign last_o       = out_valid_q & out_last_q;

  // The frame count never exceeds the stack size.
  `SCST_ASSERT(a_top_bound, clk_i, rst_ni, top_q <= TW'(StackDepth))
  // Every result word comes from a cycle in which the tracker was working.
  `SCST_ASSERT(a_valid_from_busy, clk_i, rst_ni, evt_valid_o |-> $past(busy_o))
  // The final result of a word shows once the tracker is free again.
  `SCST_ASSERT(a_last_idle, clk_i, rst_ni, last_o |-> !busy_o)
  // An unwind is always followed by the word's own call or return result.
  `SCST_ASSERT(a_unwind_not_last, clk_i, rst_ni,
               (evt_valid_o && (event_kind_o == scst_pkg::KIND_UNWIND)) |-> !last_o)
  // A push or pop moves the frame count by exactly one.
  `SCST_ASSERT(a_top_step, clk_i, rst_ni,
               (top_q != $past(top_q)) |->
                 ((top_q == $past(top_q) + TW'(1)) || (top_q == $past(top_q) - TW'(1))))

endmodule

`default_nettype wire

/* tb/call_stack_mirror_pkg.sv */
// ----------------------------------------------------------------------------
// call_stack_mirror_pkg
// Bench-side copy of the shadow call stack: predicts the result words of
// each accepted input word and checks the words the block produces.
// ----------------------------------------------------------------------------
package call_stack_mirror_pkg;

  import scst_pkg::*;

  localparam bit REQ_CALL   = 1'b0;
  localparam bit REQ_RETURN = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    kind_e              kind;
    addr_t              routine;
    addr_t              site;
    logic [DEPTH_W-1:0] depth;
    logic               is_last;
  } stack_event_t;

  class call_stack_mirror;
    addr_t        frame_sp[STACK_DEPTH];
    addr_t        frame_routine[STACK_DEPTH];
    int unsigned  frame_count;
    stack_event_t pending_events[$];
    int unsigned  mismatches;
    int unsigned  words_seen;

    function new();
      frame_count = 0;
      mismatches  = 0;
      words_seen  = 0;
    endfunction

    function int unsigned pending();
      return pending_events.size();
    endfunction

    function addr_t top_sp();
      return frame_sp[frame_count - 1];
    endfunction

    function void push_event(kind_e kind, addr_t routine, addr_t site, int unsigned depth);
      stack_event_t ev;
      ev.kind    = kind;
      ev.routine = routine;
      ev.site    = site;
      ev.depth   = DEPTH_W'(depth);
      ev.is_last = 1'b0;
      pending_events.push_back(ev);
    endfunction

    // Updates the stack copy for one accepted word and queues its results.
    function void apply_word(bit req, addr_t target, addr_t sp, addr_t site);
      stack_event_t tail;
      // Frames at or below the new stack pointer are gone, as after a longjmp.
      while (frame_count > 0 && sp >= frame_sp[frame_count - 1]) begin
        frame_count--;
        push_event(KIND_UNWIND, frame_routine[frame_count], '0, frame_count);
      end
      if (req == REQ_RETURN) begin
        if (frame_count == 0) begin
          push_event(KIND_UNDER, '0, '0, 0);
        end else begin
          frame_count--;
          push_event(KIND_RETURN, frame_routine[frame_count], '0, frame_count);
        end
      end else if (frame_count == STACK_DEPTH) begin
        push_event(KIND_OVER, target, '0, frame_count);
      end else begin
        frame_sp[frame_count]      = sp;
        frame_routine[frame_count] = target;
        frame_count++;
        push_event(KIND_ENTER, target, site, frame_count);
      end
      tail = pending_events.pop_back();
      tail.is_last = 1'b1;
      pending_events.push_back(tail);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 50) begin
        $display("[%0t] MISMATCH at result %0d: %s", $time, words_seen, what);
      end
    endtask

    task compare_event(logic [2:0] kind, addr_t routine, addr_t site,
                       logic [DEPTH_W-1:0] depth, logic is_last);
      stack_event_t want;
      words_seen++;
      if (pending_events.size() == 0) begin
        report_mismatch("result word while none was expected");
        return;
      end
      want = pending_events.pop_front();
      if (kind !== want.kind) begin
        report_mismatch($sformatf("event_kind %0d, expected %0d", kind, want.kind));
      end
      if (routine !== want.routine) begin
        report_mismatch($sformatf("routine %h, expected %h", routine, want.routine));
      end
      if (site !== want.site) begin
        report_mismatch($sformatf("site %h, expected %h", site, want.site));
      end
      if (depth !== want.depth) begin
        report_mismatch($sformatf("depth %0d, expected %0d", depth, want.depth));
      end
      if (is_last !== want.is_last) begin
        report_mismatch($sformatf("last %b, expected %b", is_last, want.is_last));
      end
    endtask
  endclass

endpackage

/* tb/tb_shadow_call_stack_tracker_core.sv */
// ----------------------------------------------------------------------------
// tb_shadow_call_stack_tracker_core
// Self-checking bench for the shadow call stack tracker. Call and return
// words go in through the start/busy handshake; every result word is checked
// against a bench-side copy of the stack as it comes out.
// ----------------------------------------------------------------------------
module tb_shadow_call_stack_tracker_core;

  timeunit 1ns;
  timeprecision 1ps;

  import scst_pkg::*;
  import call_stack_mirror_pkg::*;

  localparam int unsigned RANDOM_WORDS  = 300;
  // The limit is set well beyond the longest legal quiet stretch, a long
  // sender gap plus one fully unwinding word.
  localparam int unsigned IDLE_LIMIT    = 2000;
  // Deepest word gives 33 results, one per cycle, after a read of the top frame.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam addr_t       ALL_ONES      = '1;
  localparam addr_t       FILL_BASE     = 64'hFFFF_0000_0000_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               req_type_i;
  addr_t              target_i;
  addr_t              stack_ptr_i;
  addr_t              call_site_i;
  logic               evt_valid_o;
  logic [2:0]         event_kind_o;
  addr_t              routine_o;
  addr_t              site_o;
  logic [DEPTH_W-1:0] depth_o;
  logic               last_o;

  call_stack_mirror mirror;

  // Words left in a stretch where the sender inserts no idle cycles.
  int unsigned calm_words = 0;
  // Depth the random stimulus steers toward; above STACK_DEPTH it forces
  // repeated calls on a full stack.
  int unsigned depth_goal = STACK_DEPTH / 2;

  shadow_call_stack_tracker_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .target_i     (target_i),
    .stack_ptr_i  (stack_ptr_i),
    .call_site_i  (call_site_i),
    .evt_valid_o  (evt_valid_o),
    .event_kind_o (event_kind_o),
    .routine_o    (routine_o),
    .site_o       (site_o),
    .depth_o      (depth_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic addr_t rand64();
    return {$urandom, $urandom};
  endfunction

  // A stack pointer a little below the given one, so the word nests deeper.
  function automatic addr_t below(addr_t sp, int unsigned span);
    return (sp > span) ? sp - $urandom_range(1, span) : sp >> 1;
  endfunction

  // Mostly back-to-back words, some short gaps, a few long ones, and now and
  // then a stretch of words with no gaps at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_words > 0) begin
      calm_words--;
      return 0;
    end
    if (r < 4) calm_words = $urandom_range(10, 30);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one word and returns at the edge that accepts it. start_i stays
  // high afterwards, so a following word with no gap goes out at once; the
  // old word's fields are replaced in the same step they are accepted.
  task automatic send_word(input bit req, input addr_t tgt, input addr_t sp, input addr_t site);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      // Junk on the fields while start is low must be ignored.
      start_i     <= 1'b0;
      req_type_i  <= 1'($urandom_range(0, 1));
      target_i    <= rand64();
      stack_ptr_i <= rand64();
      call_site_i <= rand64();
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    req_type_i  <= req;
    target_i    <= tgt;
    stack_ptr_i <= sp;
    call_site_i <= site;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    mirror.apply_word(req, tgt, sp, site);
  endtask

  // Holds the sender off until every predicted result has come out. At least
  // one edge passes, so start_i is never lowered and raised in one step.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (mirror.pending() != 0);
  endtask

  // Random words. Most follow a plausible program: calls nest with falling
  // stack pointers, returns come from inside the top frame. Some jump back
  // to an older frame's stack pointer to unwind several frames, and a few
  // are plain noise.
  function automatic void pick_random_word(output bit req, output addr_t tgt,
                                           output addr_t sp, output addr_t site);
    int unsigned r;
    int unsigned k;
    r    = $urandom_range(0, 99);
    tgt  = rand64();
    site = rand64();
    if ($urandom_range(0, 15) == 0) begin
      depth_goal = ($urandom_range(0, 4) == 0) ? STACK_DEPTH + 1
                                               : $urandom_range(0, STACK_DEPTH);
    end
    if (r < 8) begin
      req = 1'($urandom_range(0, 1));
      sp  = rand64();
    end else if (r < 18 && mirror.frame_count > 0) begin
      k  = $urandom_range(0, mirror.frame_count - 1);
      sp = mirror.frame_sp[k];
      if (sp != ALL_ONES) sp = sp + $urandom_range(0, 1);
      req = 1'($urandom_range(0, 1));
    end else if (mirror.frame_count < depth_goal) begin
      req = REQ_CALL;
      // A fresh outermost frame starts high enough for a full stack below it.
      sp  = (mirror.frame_count == 0) ? (rand64() | (addr_t'(1) << 40))
                                      : below(mirror.top_sp(), 256);
    end else begin
      req = REQ_RETURN;
      sp  = (mirror.frame_count == 0) ? rand64() : below(mirror.top_sp(), 16);
    end
  endfunction

  // Every result word is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (evt_valid_o === 1'b1) begin
        mirror.compare_event(event_kind_o, routine_o, site_o, depth_o, last_o);
      end else if (evt_valid_o !== 1'b0) begin
        mirror.report_mismatch("evt_valid_o is unknown");
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((rst_ni && start_i && !busy_o) || evt_valid_o) quiet = 0;
      else quiet++;
    end
    $display("tb_shadow_call_stack_tracker_core: errors");
    $finish;
  end

  initial begin : stimulus
    bit    req;
    addr_t tgt;
    addr_t sp;
    addr_t site;

    mirror = new();
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_type_i  <= REQ_CALL;
    target_i    <= '0;
    stack_ptr_i <= '0;
    call_site_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Returns on an empty stack underflow; target and call site are ignored.
    send_word(REQ_RETURN, rand64(), rand64(), rand64());
    send_word(REQ_RETURN, ALL_ONES, '0, ALL_ONES);
    // A call at the top of the address space, then one at the same stack
    // pointer: the equal pointer unwinds the first frame before the push.
    send_word(REQ_CALL, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(REQ_CALL, '0, ALL_ONES, '0);
    send_word(REQ_RETURN, ALL_ONES, '0, ALL_ONES);
    // A frame at stack pointer zero is unwound by any later word, so the
    // return after it unwinds and then underflows.
    send_word(REQ_CALL, rand64(), '0, rand64());
    send_word(REQ_RETURN, rand64(), '0, rand64());

    // Fill the stack to the limit, then call on the full stack (overflow).
    for (int unsigned i = 0; i < STACK_DEPTH; i++) begin
      send_word(REQ_CALL, rand64(), FILL_BASE - 64 * i, rand64());
    end
    send_word(REQ_CALL, rand64(), below(mirror.top_sp(), 8), rand64());
    // On a full stack a call that unwinds the top frame pushes normally.
    send_word(REQ_CALL, rand64(), mirror.top_sp(), rand64());
    send_word(REQ_RETURN, rand64(), below(mirror.top_sp(), 8), rand64());
    send_word(REQ_CALL, rand64(), below(mirror.top_sp(), 8), rand64());
    // A return from the very top unwinds all frames and then underflows,
    // the longest burst of results one word can cause.
    send_word(REQ_RETURN, rand64(), ALL_ONES, rand64());
    // Alternating bit patterns on the stack pointer and addresses.
    send_word(REQ_CALL, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
              64'hAAAA_AAAA_AAAA_AAAA);
    send_word(REQ_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 64'h2AAA_AAAA_AAAA_AAAA,
              64'h5555_5555_5555_5555);
    send_word(REQ_RETURN, '0, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    drain();

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      pick_random_word(req, tgt, sp, site);
      send_word(req, tgt, sp, site);
      if (n % 70 == 69) drain();
    end

    // Wait for the last results, then a little longer for anything stray.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("tb_shadow_call_stack_tracker_core: clean");
    end else begin
      $display("tb_shadow_call_stack_tracker_core: errors");
    end
    $finish;
  end

endmodule

/* shadow_call_stack_tracker_core.f */
+incdir+rtl
rtl/scst_pkg.sv
rtl/scst_frame_ram.sv
rtl/shadow_call_stack_tracker_core.sv
tb/call_stack_mirror_pkg.sv
tb/tb_shadow_call_stack_tracker_core.sv
